### sv/qgrad_pkg.sv
// qgrad_pkg: shared sizes, field widths, codes and types of the gradient unit
// used by qgrad_mac and quadratic_gradient_qx_minus_c_unit
// no dependencies
package qgrad_pkg;

    // store dimensions
    localparam int MAX_ROWS  = 16;
    localparam int MAX_INNER = 16;
    localparam int MAX_COLS  = 4;

    // item and register field widths
    localparam int ACTION_W    = 2;
    localparam int IDX_W       = 4;
    localparam int VALUE_W     = 16;
    localparam int ROW_CFG_W   = 5;
    localparam int INNER_CFG_W = 5;
    localparam int COL_CFG_W   = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int OUT_ROW_W   = 4;
    localparam int OUT_COL_W   = 2;
    localparam int GRAD_W      = 32;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD_Q  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_X  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOAD_C  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INNER_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COL_COUNT   = 2'd2;

    // loop counter widths (index) and dimension widths (count)
    localparam int ROW_IW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int INNER_IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int COL_IW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
    localparam int INNER_W  = $clog2(MAX_INNER + 1);
    localparam int COLS_W   = $clog2(MAX_COLS + 1);

    // memory geometry
    localparam int Q_DEPTH = MAX_ROWS * MAX_INNER;
    localparam int X_DEPTH = MAX_INNER * MAX_COLS;
    localparam int C_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int X_AW    = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
    localparam int C_AW    = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;

    // datapath widths
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int ACC_W   = PROD_W + INNER_IW + 1;
    localparam int DIFF_W  = ACC_W + 1;
    localparam int C_SHIFT = 8;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctl;

endpackage

### sv/quadratic_gradient_qx_minus_c_unit.sv
// quadratic_gradient_qx_minus_c_unit: top level, gradient Q*x - c engine
// depends on qgrad_pkg, qgrad_ram, qgrad_mac
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_action i_row i_col i_value
//  out     | output    | o_out_valid / i_out_ready | o_out_row o_out_col o_gradient
//          |           |                           | o_saturated o_last
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index i_cfg_data
//
// a load item is written to its store as it is accepted; the next item can follow at once
// a compute item works through rows * cols gradient elements: one memory read
//   and one pass through the single shared multiplier per product, plus a
//   drain and result step per gradient element
// the block accepts no item while a compute item is running
// a finished element waits in the output register; the sequencer stalls there
//   only when the next element is ready and the register is still full
// synchronous active-low reset clears control and restores the registers to
//   16, 16, 1; store contents are undefined until loaded
module quadratic_gradient_qx_minus_c_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // item input
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [qgrad_pkg::ACTION_W-1:0]           i_action,
    input  logic [qgrad_pkg::IDX_W-1:0]              i_row,
    input  logic [qgrad_pkg::IDX_W-1:0]              i_col,
    input  logic signed [qgrad_pkg::VALUE_W-1:0]     i_value,
    // result output
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic [qgrad_pkg::OUT_ROW_W-1:0]          o_out_row,
    output logic [qgrad_pkg::OUT_COL_W-1:0]          o_out_col,
    output logic signed [qgrad_pkg::GRAD_W-1:0]      o_gradient,
    output logic                                     o_saturated,
    output logic                                     o_last,
    // register writes
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [qgrad_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [qgrad_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [qgrad_pkg::ROW_CFG_W-1:0]   r_row_count;
    logic [qgrad_pkg::INNER_CFG_W-1:0] r_inner_count;
    logic [qgrad_pkg::COL_CFG_W-1:0]   r_col_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count   <= qgrad_pkg::ROW_CFG_W'(16);
            r_inner_count <= qgrad_pkg::INNER_CFG_W'(16);
            r_col_count   <= qgrad_pkg::COL_CFG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                qgrad_pkg::CFG_ROW_COUNT: begin
                    r_row_count <= qgrad_pkg::ROW_CFG_W'(i_cfg_data);
                end
                qgrad_pkg::CFG_INNER_COUNT: begin
                    r_inner_count <= qgrad_pkg::INNER_CFG_W'(i_cfg_data);
                end
                qgrad_pkg::CFG_COL_COUNT: begin
                    r_col_count <= qgrad_pkg::COL_CFG_W'(i_cfg_data);
                end
                default: begin
                    // unknown register, write dropped
                end
            endcase
        end
    end

    // effective dimensions: zero acts as one, above the store size acts as the size
    logic [qgrad_pkg::ROWS_W-1:0]  w_rows;
    logic [qgrad_pkg::INNER_W-1:0] w_inner;
    logic [qgrad_pkg::COLS_W-1:0]  w_cols;

    always_comb begin
        if (r_row_count == '0) begin
            w_rows = qgrad_pkg::ROWS_W'(1);
        end else if (int'(r_row_count) > qgrad_pkg::MAX_ROWS) begin
            w_rows = qgrad_pkg::ROWS_W'(qgrad_pkg::MAX_ROWS);
        end else begin
            w_rows = qgrad_pkg::ROWS_W'(r_row_count);
        end
        if (r_inner_count == '0) begin
            w_inner = qgrad_pkg::INNER_W'(1);
        end else if (int'(r_inner_count) > qgrad_pkg::MAX_INNER) begin
            w_inner = qgrad_pkg::INNER_W'(qgrad_pkg::MAX_INNER);
        end else begin
            w_inner = qgrad_pkg::INNER_W'(r_inner_count);
        end
        if (r_col_count == '0) begin
            w_cols = qgrad_pkg::COLS_W'(1);
        end else if (int'(r_col_count) > qgrad_pkg::MAX_COLS) begin
            w_cols = qgrad_pkg::COLS_W'(qgrad_pkg::MAX_COLS);
        end else begin
            w_cols = qgrad_pkg::COLS_W'(r_col_count);
        end
    end

    // ---------------------------------------------------------------
    // sequencer registers
    // ---------------------------------------------------------------
    logic [1:0]                       r_state;
    logic [1:0]                       n_state;
    logic [qgrad_pkg::ROW_IW-1:0]     r_i;
    logic [qgrad_pkg::ROW_IW-1:0]     n_i;
    logic [qgrad_pkg::COL_IW-1:0]     r_j;
    logic [qgrad_pkg::COL_IW-1:0]     n_j;
    logic [qgrad_pkg::INNER_IW-1:0]   r_m;
    logic [qgrad_pkg::INNER_IW-1:0]   n_m;
    logic                             r_rd_vld;

    logic w_in_fire;
    logic w_issue;
    logic w_m_last;
    logic w_i_last;
    logic w_j_last;
    logic w_emit;
    logic w_mac_busy;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_issue    = (r_state == S_MAC);
    assign w_m_last   = (qgrad_pkg::INNER_W'(r_m) + qgrad_pkg::INNER_W'(1)) == w_inner;
    assign w_i_last   = (qgrad_pkg::ROWS_W'(r_i) + qgrad_pkg::ROWS_W'(1)) == w_rows;
    assign w_j_last   = (qgrad_pkg::COLS_W'(r_j) + qgrad_pkg::COLS_W'(1)) == w_cols;

    // element done once the read and product stages are empty and the
    // output register can take it
    assign w_emit = (r_state == S_DRAIN) && !r_rd_vld && !w_mac_busy &&
                    (!o_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_m     = r_m;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire && (i_action == qgrad_pkg::ACT_COMPUTE)) begin
                    n_state = S_MAC;
                    n_i     = '0;
                    n_j     = '0;
                    n_m     = '0;
                end
            end
            S_MAC: begin
                if (w_m_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_m = r_m + qgrad_pkg::INNER_IW'(1);
                end
            end
            S_DRAIN: begin
                if (w_emit) begin
                    n_m = '0;
                    if (w_j_last) begin
                        n_j = '0;
                        if (w_i_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_i     = r_i + qgrad_pkg::ROW_IW'(1);
                            n_state = S_MAC;
                        end
                    end else begin
                        n_j     = r_j + qgrad_pkg::COL_IW'(1);
                        n_state = S_MAC;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_i      <= '0;
            r_j      <= '0;
            r_m      <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_j      <= n_j;
            r_m      <= n_m;
            r_rd_vld <= w_issue;
        end
    end

    // ---------------------------------------------------------------
    // stores: written by load items, read by the sequencer
    // ---------------------------------------------------------------
    logic                               w_q_we;
    logic                               w_x_we;
    logic                               w_c_we;
    logic [qgrad_pkg::Q_AW-1:0]         w_q_waddr;
    logic [qgrad_pkg::X_AW-1:0]         w_x_waddr;
    logic [qgrad_pkg::C_AW-1:0]         w_c_waddr;
    logic [qgrad_pkg::Q_AW-1:0]         w_q_raddr;
    logic [qgrad_pkg::X_AW-1:0]         w_x_raddr;
    logic [qgrad_pkg::C_AW-1:0]         w_c_raddr;
    logic [qgrad_pkg::VALUE_W-1:0]      w_q_rdata;
    logic [qgrad_pkg::VALUE_W-1:0]      w_x_rdata;
    logic [qgrad_pkg::VALUE_W-1:0]      w_c_rdata;

    // loads outside a store's dimensions are dropped
    assign w_q_we = w_in_fire && (i_action == qgrad_pkg::ACT_LOAD_Q) &&
                    (int'(i_row) < qgrad_pkg::MAX_ROWS) &&
                    (int'(i_col) < qgrad_pkg::MAX_INNER);
    assign w_x_we = w_in_fire && (i_action == qgrad_pkg::ACT_LOAD_X) &&
                    (int'(i_row) < qgrad_pkg::MAX_INNER) &&
                    (int'(i_col) < qgrad_pkg::MAX_COLS);
    assign w_c_we = w_in_fire && (i_action == qgrad_pkg::ACT_LOAD_C) &&
                    (int'(i_row) < qgrad_pkg::MAX_ROWS) &&
                    (int'(i_col) < qgrad_pkg::MAX_COLS);

    assign w_q_waddr = qgrad_pkg::Q_AW'(i_row) * qgrad_pkg::Q_AW'(qgrad_pkg::MAX_INNER)
                     + qgrad_pkg::Q_AW'(i_col);
    assign w_x_waddr = qgrad_pkg::X_AW'(i_row) * qgrad_pkg::X_AW'(qgrad_pkg::MAX_COLS)
                     + qgrad_pkg::X_AW'(i_col);
    assign w_c_waddr = qgrad_pkg::C_AW'(i_row) * qgrad_pkg::C_AW'(qgrad_pkg::MAX_COLS)
                     + qgrad_pkg::C_AW'(i_col);

    // row-major reads: q[i][m], x[m][j], c[i][j]
    assign w_q_raddr = qgrad_pkg::Q_AW'(r_i) * qgrad_pkg::Q_AW'(qgrad_pkg::MAX_INNER)
                     + qgrad_pkg::Q_AW'(r_m);
    assign w_x_raddr = qgrad_pkg::X_AW'(r_m) * qgrad_pkg::X_AW'(qgrad_pkg::MAX_COLS)
                     + qgrad_pkg::X_AW'(r_j);
    assign w_c_raddr = qgrad_pkg::C_AW'(r_i) * qgrad_pkg::C_AW'(qgrad_pkg::MAX_COLS)
                     + qgrad_pkg::C_AW'(r_j);

    qgrad_ram #(
        .WIDTH (qgrad_pkg::VALUE_W),
        .DEPTH (qgrad_pkg::Q_DEPTH)
    ) u_q_ram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_q_waddr),
        .i_wdata (i_value),
        .i_re    (w_issue),
        .i_raddr (w_q_raddr),
        .o_rdata (w_q_rdata)
    );

    qgrad_ram #(
        .WIDTH (qgrad_pkg::VALUE_W),
        .DEPTH (qgrad_pkg::X_DEPTH)
    ) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (w_x_we),
        .i_waddr (w_x_waddr),
        .i_wdata (i_value),
        .i_re    (w_issue),
        .i_raddr (w_x_raddr),
        .o_rdata (w_x_rdata)
    );

    // c read data holds after the last issue, used at the result step
    qgrad_ram #(
        .WIDTH (qgrad_pkg::VALUE_W),
        .DEPTH (qgrad_pkg::C_DEPTH)
    ) u_c_ram (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_waddr (w_c_waddr),
        .i_wdata (i_value),
        .i_re    (w_issue),
        .i_raddr (w_c_raddr),
        .o_rdata (w_c_rdata)
    );

    // ---------------------------------------------------------------
    // shared multiply-accumulate
    // ---------------------------------------------------------------
    qgrad_pkg::t_mac_ctl                    w_mac_ctl;
    logic signed [qgrad_pkg::ACC_W-1:0]     w_acc;

    // clear on the result step, after the sum has been taken
    assign w_mac_ctl.clear = w_emit;
    assign w_mac_ctl.valid = r_rd_vld;

    qgrad_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     ($signed(w_q_rdata)),
        .i_b     ($signed(w_x_rdata)),
        .o_acc   (w_acc),
        .o_busy  (w_mac_busy)
    );

    // ---------------------------------------------------------------
    // subtract c (widened to q16.16) and saturate to 32 bits
    // ---------------------------------------------------------------
    logic signed [qgrad_pkg::DIFF_W-1:0] w_c_ext;
    logic signed [qgrad_pkg::DIFF_W-1:0] w_diff;
    logic                                w_sat_hi;
    logic                                w_sat_lo;
    logic signed [qgrad_pkg::GRAD_W-1:0] w_grad;

    assign w_c_ext = qgrad_pkg::DIFF_W'($signed(w_c_rdata)) <<< qgrad_pkg::C_SHIFT;
    assign w_diff  = qgrad_pkg::DIFF_W'(w_acc) - w_c_ext;

    // clipped when the bits above the 32-bit sign disagree with it
    assign w_sat_hi = !w_diff[qgrad_pkg::DIFF_W-1] &&
                      (|w_diff[qgrad_pkg::DIFF_W-2:qgrad_pkg::GRAD_W-1]);
    assign w_sat_lo = w_diff[qgrad_pkg::DIFF_W-1] &&
                      !(&w_diff[qgrad_pkg::DIFF_W-2:qgrad_pkg::GRAD_W-1]);

    always_comb begin
        priority if (w_sat_hi) begin
            w_grad = {1'b0, {(qgrad_pkg::GRAD_W-1){1'b1}}};
        end else if (w_sat_lo) begin
            w_grad = {1'b1, {(qgrad_pkg::GRAD_W-1){1'b0}}};
        end else begin
            w_grad = w_diff[qgrad_pkg::GRAD_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic                                   r_out_valid;
    logic [qgrad_pkg::OUT_ROW_W-1:0]        r_out_row;
    logic [qgrad_pkg::OUT_COL_W-1:0]        r_out_col;
    logic signed [qgrad_pkg::GRAD_W-1:0]    r_gradient;
    logic                                   r_saturated;
    logic                                   r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_row   <= qgrad_pkg::OUT_ROW_W'(r_i);
            r_out_col   <= qgrad_pkg::OUT_COL_W'(r_j);
            r_gradient  <= w_grad;
            r_saturated <= w_sat_hi || w_sat_lo;
            r_last      <= w_i_last && w_j_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_gradient  = r_gradient;
    assign o_saturated = r_saturated;
    assign o_last      = r_last;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_idle_no_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_issue)
        else $error("memory read issued while idle");

    a_compute_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (i_action == qgrad_pkg::ACT_COMPUTE)) |=> (r_state == S_MAC))
        else $error("compute item did not start the sequencer");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_i_last && w_j_last) |=> (r_state == S_IDLE))
        else $error("run continued past its last element");

    a_mid_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (r_state != S_IDLE))
        else $error("non-last element shown with the sequencer idle");

    a_emit_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_rd_vld && !w_mac_busy && !w_issue))
        else $error("result taken with products still in flight");

endmodule

### sv/qgrad_ram.sv
// qgrad_ram: generic one-write one-read memory with registered read data
// no dependencies
module qgrad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/qgrad_mac.sv
// qgrad_mac: shared multiply-accumulate unit, product registered before the add
// depends on qgrad_pkg
module qgrad_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  qgrad_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [qgrad_pkg::VALUE_W-1:0]  i_a,
    input  logic signed [qgrad_pkg::VALUE_W-1:0]  i_b,
    output logic signed [qgrad_pkg::ACC_W-1:0]    o_acc,
    output logic                                  o_busy
);

    logic signed [qgrad_pkg::PROD_W-1:0] r_prod;
    logic                                r_prod_vld;
    logic signed [qgrad_pkg::ACC_W-1:0]  r_acc;
    logic signed [qgrad_pkg::ACC_W-1:0]  n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (r_prod_vld) begin
            n_acc = r_acc + qgrad_pkg::ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_prod_vld <= i_ctl.valid;
            r_acc      <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_prod_vld;

endmodule

### tb/quadratic_gradient_qx_minus_c_unit_test.sv
// quadratic_gradient_qx_minus_c_unit_test: self-checking bench for the Q*x - c gradient unit
// predicts every gradient element from its own copy of the stores and registers
// depends on qgrad_pkg and quadratic_gradient_qx_minus_c_unit
`timescale 1ns / 100ps

module quadratic_gradient_qx_minus_c_unit_test;

    // index with no register behind it, writes there must change nothing
    localparam logic [qgrad_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    localparam int  LIMIT_CYCLES    = 1_000_000;
    localparam int  HOLD_OFF_CYCLES = 600;
    localparam int  SETTLE_CYCLES   = 8;
    localparam int  ITEM_TARGET     = 200;

    // one gradient element as it leaves the block
    typedef struct packed {
        logic [qgrad_pkg::OUT_ROW_W-1:0]     row;
        logic [qgrad_pkg::OUT_COL_W-1:0]     col;
        logic signed [qgrad_pkg::GRAD_W-1:0] grad;
        logic                                sat;
        logic                                last;
    } t_grad_elem;

    // one planned load item
    typedef struct {
        logic [qgrad_pkg::ACTION_W-1:0]       action;
        logic [qgrad_pkg::IDX_W-1:0]          row;
        logic [qgrad_pkg::IDX_W-1:0]          col;
        logic signed [qgrad_pkg::VALUE_W-1:0] value;
    } t_load;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    // gradient scoreboard: mirrors stores and registers, queues the predicted elements
    class t_qx_minus_c_scoreboard;
        bit signed [qgrad_pkg::VALUE_W-1:0] q_mem [qgrad_pkg::MAX_ROWS][qgrad_pkg::MAX_INNER];
        bit signed [qgrad_pkg::VALUE_W-1:0] x_mem [qgrad_pkg::MAX_INNER][qgrad_pkg::MAX_COLS];
        bit signed [qgrad_pkg::VALUE_W-1:0] c_mem [qgrad_pkg::MAX_ROWS][qgrad_pkg::MAX_COLS];
        bit [qgrad_pkg::ROW_CFG_W-1:0]      row_reg;
        bit [qgrad_pkg::INNER_CFG_W-1:0]    inner_reg;
        bit [qgrad_pkg::COL_CFG_W-1:0]      col_reg;
        t_grad_elem                         pending_elements[$];
        int                                 failures;

        function new();
            row_reg   = 16;
            inner_reg = 16;
            col_reg   = 1;
            failures  = 0;
        endfunction

        // zero acts as one, anything above the store size acts as the size
        function int clamp_count(int raw, int hi);
            if (raw < 1) return 1;
            if (raw > hi) return hi;
            return raw;
        endfunction

        function int rows_in_use();
            return clamp_count(row_reg, qgrad_pkg::MAX_ROWS);
        endfunction

        function int inner_in_use();
            return clamp_count(inner_reg, qgrad_pkg::MAX_INNER);
        endfunction

        function int cols_in_use();
            return clamp_count(col_reg, qgrad_pkg::MAX_COLS);
        endfunction

        function void write_register(logic [qgrad_pkg::CFG_INDEX_W-1:0] index,
                                     logic [qgrad_pkg::CFG_DATA_W-1:0] data);
            case (index)
                qgrad_pkg::CFG_ROW_COUNT:   row_reg   = data[qgrad_pkg::ROW_CFG_W-1:0];
                qgrad_pkg::CFG_INNER_COUNT: inner_reg = data[qgrad_pkg::INNER_CFG_W-1:0];
                qgrad_pkg::CFG_COL_COUNT:   col_reg   = data[qgrad_pkg::COL_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        function void predict_qx_minus_c();
            int         rows;
            int         inner;
            int         cols;
            longint     acc;
            t_grad_elem e;
            rows  = rows_in_use();
            inner = inner_in_use();
            cols  = cols_in_use();
            for (int i = 0; i < rows; i++) begin
                for (int j = 0; j < cols; j++) begin
                    acc = 0;
                    for (int m = 0; m < inner; m++)
                        acc += longint'(q_mem[i][m]) * longint'(x_mem[m][j]);
                    // c is Q8.8, widen to Q16.16 before subtracting
                    acc -= longint'(c_mem[i][j]) * 256;
                    e.sat = 1'b0;
                    if (acc > 64'sh7FFF_FFFF) begin
                        acc   = 64'sh7FFF_FFFF;
                        e.sat = 1'b1;
                    end else if (acc < -64'sh8000_0000) begin
                        acc   = -64'sh8000_0000;
                        e.sat = 1'b1;
                    end
                    e.row  = i[qgrad_pkg::OUT_ROW_W-1:0];
                    e.col  = j[qgrad_pkg::OUT_COL_W-1:0];
                    e.grad = acc[qgrad_pkg::GRAD_W-1:0];
                    e.last = (i == rows - 1) && (j == cols - 1);
                    pending_elements.push_back(e);
                end
            end
        endfunction

        // called for every accepted input item
        function void take_item(logic [qgrad_pkg::ACTION_W-1:0] action,
                                logic [qgrad_pkg::IDX_W-1:0] row,
                                logic [qgrad_pkg::IDX_W-1:0] col,
                                logic signed [qgrad_pkg::VALUE_W-1:0] value);
            case (action)
                qgrad_pkg::ACT_LOAD_Q:
                    if (row < qgrad_pkg::MAX_ROWS && col < qgrad_pkg::MAX_INNER)
                        q_mem[row][col] = value;
                qgrad_pkg::ACT_LOAD_X:
                    if (row < qgrad_pkg::MAX_INNER && col < qgrad_pkg::MAX_COLS)
                        x_mem[row][col] = value;
                qgrad_pkg::ACT_LOAD_C:
                    if (row < qgrad_pkg::MAX_ROWS && col < qgrad_pkg::MAX_COLS)
                        c_mem[row][col] = value;
                default:
                    predict_qx_minus_c();
            endcase
        endfunction

        // called for every accepted result item
        function void match_element(logic [qgrad_pkg::OUT_ROW_W-1:0] row,
                                    logic [qgrad_pkg::OUT_COL_W-1:0] col,
                                    logic signed [qgrad_pkg::GRAD_W-1:0] grad,
                                    logic sat, logic last);
            t_grad_elem e;
            if (pending_elements.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected element: row %0d col %0d gradient %0d sat %0b last %0b",
                             row, col, grad, sat, last);
                return;
            end
            e = pending_elements.pop_front();
            if (row !== e.row || col !== e.col || grad !== e.grad || sat !== e.sat
                    || last !== e.last) begin
                failures++;
                if (failures <= 10) begin
                    $write("element mismatch: expected row %0d col %0d gradient %0d sat %0b",
                           e.row, e.col, e.grad, e.sat);
                    $display(" last %0b, got row %0d col %0d gradient %0d sat %0b last %0b",
                             e.last, row, col, grad, sat, last);
                end
            end
        endfunction

        function int pending();
            return pending_elements.size();
        endfunction
    endclass

    // block ports
    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n;
    logic                                   i_in_valid;
    logic                                   o_in_ready;
    logic [qgrad_pkg::ACTION_W-1:0]         i_action;
    logic [qgrad_pkg::IDX_W-1:0]            i_row;
    logic [qgrad_pkg::IDX_W-1:0]            i_col;
    logic signed [qgrad_pkg::VALUE_W-1:0]   i_value;
    logic                                   o_out_valid;
    logic                                   i_out_ready;
    logic [qgrad_pkg::OUT_ROW_W-1:0]        o_out_row;
    logic [qgrad_pkg::OUT_COL_W-1:0]        o_out_col;
    logic signed [qgrad_pkg::GRAD_W-1:0]    o_gradient;
    logic                                   o_saturated;
    logic                                   o_last;
    logic                                   i_cfg_valid;
    logic                                   o_cfg_ready;
    logic [qgrad_pkg::CFG_INDEX_W-1:0]      i_cfg_index;
    logic [qgrad_pkg::CFG_DATA_W-1:0]       i_cfg_data;

    t_qx_minus_c_scoreboard grad_board = new();

    // which store entries have been loaded, computes never touch anything else
    bit         q_written [qgrad_pkg::MAX_ROWS][qgrad_pkg::MAX_INNER];
    bit         x_written [qgrad_pkg::MAX_INNER][qgrad_pkg::MAX_COLS];
    bit         c_written [qgrad_pkg::MAX_ROWS][qgrad_pkg::MAX_COLS];
    int         stored_items = 0;
    t_idle_mode idle_mode = IDLE_NONE;
    int         hold_off_asks = 0;
    int         cycle_count = 0;

    quadratic_gradient_qx_minus_c_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_gradient  (o_gradient),
        .o_saturated (o_saturated),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // watchdog, sized far beyond the slowest legal run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("quadratic_gradient_qx_minus_c_unit verification failed");
            $finish;
        end
    end

    // results are taken at the rising edge, where ready was set up at the falling one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            grad_board.match_element(o_out_row, o_out_col, o_gradient, o_saturated, o_last);
    end

    function automatic bit sender_rests();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 80;
            IDLE_BOTH:   return $urandom_range(0, 99) < 15;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_rests();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 80;
            IDLE_BOTH:     return $urandom_range(0, 99) < 15;
            default:       return 1'b0;
        endcase
    endfunction

    // receiver side: random stalls, plus a long hold-off whenever one is asked for
    initial begin
        int hold_off_left;
        int hold_off_seen;
        hold_off_left = 0;
        hold_off_seen = 0;
        i_out_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_asks != hold_off_seen) begin
                hold_off_seen = hold_off_asks;
                hold_off_left = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0) begin
                i_out_ready = 1'b0;
                hold_off_left--;
            end else begin
                i_out_ready = !receiver_rests();
            end
        end
    end

    // mostly full-range values, with the extremes and small magnitudes mixed in
    function automatic logic signed [qgrad_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return $signed(16'($urandom_range(0, 511))) - 16'sd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // entered and left just after a falling edge; valid stays up between back-to-back items
    task automatic offer_item(input logic [qgrad_pkg::ACTION_W-1:0] action,
                              input logic [qgrad_pkg::IDX_W-1:0] row,
                              input logic [qgrad_pkg::IDX_W-1:0] col,
                              input logic signed [qgrad_pkg::VALUE_W-1:0] value);
        while (sender_rests()) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_action   = action;
        i_row      = row;
        i_col      = col;
        i_value    = value;
        do @(posedge i_clk); while (!o_in_ready);
        grad_board.take_item(action, row, col, value);
        @(negedge i_clk);
    endtask

    task automatic load_element(input logic [qgrad_pkg::ACTION_W-1:0] action,
                                input logic [qgrad_pkg::IDX_W-1:0] row,
                                input logic [qgrad_pkg::IDX_W-1:0] col,
                                input logic signed [qgrad_pkg::VALUE_W-1:0] value);
        offer_item(action, row, col, value);
        // out-of-range loads are dropped by the block and don't count
        case (action)
            qgrad_pkg::ACT_LOAD_Q: begin
                q_written[row][col] = 1'b1;
                stored_items++;
            end
            qgrad_pkg::ACT_LOAD_X: if (col < qgrad_pkg::MAX_COLS) begin
                x_written[row][col] = 1'b1;
                stored_items++;
            end
            qgrad_pkg::ACT_LOAD_C: if (col < qgrad_pkg::MAX_COLS) begin
                c_written[row][col] = 1'b1;
                stored_items++;
            end
            default: ;
        endcase
    endtask

    // the index and value fields of a compute item carry no meaning, so they get noise
    task automatic run_compute();
        offer_item(qgrad_pkg::ACT_COMPUTE, 4'($urandom), 4'($urandom), 16'($urandom));
        stored_items++;
    endtask

    task automatic write_register(input logic [qgrad_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [qgrad_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        grad_board.write_register(index, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_dims(input logic [qgrad_pkg::CFG_DATA_W-1:0] rows,
                            input logic [qgrad_pkg::CFG_DATA_W-1:0] inner,
                            input logic [qgrad_pkg::CFG_DATA_W-1:0] cols);
        write_register(qgrad_pkg::CFG_ROW_COUNT, rows);
        write_register(qgrad_pkg::CFG_INNER_COUNT, inner);
        write_register(qgrad_pkg::CFG_COL_COUNT, cols);
        if ($urandom_range(0, 2) == 0)
            write_register(CFG_UNUSED_INDEX, 5'($urandom));
    endtask

    // registers only change with nothing in flight: all results in, then a settling
    // wait of SETTLE_CYCLES, since a trailing load leaves no result to wait for
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (grad_board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // one problem: load whatever the active region still lacks plus some rewrites and
    // stray loads, in random order, then compute; now and then the sequence breaks off
    task automatic run_problem();
        t_load plan[$];
        t_load tmp;
        int    rows;
        int    inner;
        int    cols;
        int    refresh;
        int    swap;
        bit    broken;
        rows    = grad_board.rows_in_use();
        inner   = grad_board.inner_in_use();
        cols    = grad_board.cols_in_use();
        // rewrite less often when the region is big, to keep item counts sane
        refresh = (rows * inner > 16) ? 16 : 4;
        for (int i = 0; i < rows; i++)
            for (int m = 0; m < inner; m++)
                if (!q_written[i][m] || $urandom_range(0, refresh - 1) == 0)
                    plan.push_back('{qgrad_pkg::ACT_LOAD_Q, 4'(i), 4'(m), pick_value()});
        for (int m = 0; m < inner; m++)
            for (int j = 0; j < cols; j++)
                if (!x_written[m][j] || $urandom_range(0, refresh - 1) == 0)
                    plan.push_back('{qgrad_pkg::ACT_LOAD_X, 4'(m), 4'(j), pick_value()});
        for (int i = 0; i < rows; i++)
            for (int j = 0; j < cols; j++)
                if (!c_written[i][j] || $urandom_range(0, refresh - 1) == 0)
                    plan.push_back('{qgrad_pkg::ACT_LOAD_C, 4'(i), 4'(j), pick_value()});
        repeat ($urandom_range(0, 3))
            plan.push_back('{2'($urandom_range(0, 2)), 4'($urandom), 4'($urandom), pick_value()});
        for (int k = plan.size() - 1; k > 0; k--) begin
            swap       = $urandom_range(0, k);
            tmp        = plan[k];
            plan[k]    = plan[swap];
            plan[swap] = tmp;
        end
        broken = ($urandom_range(0, 9) == 0);
        if (broken)
            while (plan.size() > 1 && plan.size() > $urandom_range(0, 8))
                void'(plan.pop_back());
        foreach (plan[k])
            load_element(plan[k].action, plan[k].row, plan[k].col, plan[k].value);
        if (!broken)
            run_compute();
    endtask

    initial begin
        int phase;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_action    = qgrad_pkg::ACT_LOAD_Q;
        i_row       = '0;
        i_col       = '0;
        i_value     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = qgrad_pkg::CFG_ROW_COUNT;
        i_cfg_data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: 2x2x2 problem built to hit both saturation directions and two
        // in-range elements, with value extremes on every store
        set_dims(5'd2, 5'd2, 5'd2);
        load_element(qgrad_pkg::ACT_LOAD_Q, 4'd0, 4'd0, 16'sh8000);
        load_element(qgrad_pkg::ACT_LOAD_Q, 4'd0, 4'd1, 16'sh8000);
        load_element(qgrad_pkg::ACT_LOAD_Q, 4'd1, 4'd0, 16'sh7FFF);
        load_element(qgrad_pkg::ACT_LOAD_Q, 4'd1, 4'd1, 16'sh7FFF);
        load_element(qgrad_pkg::ACT_LOAD_X, 4'd0, 4'd0, 16'sh8000);
        load_element(qgrad_pkg::ACT_LOAD_X, 4'd1, 4'd0, 16'sh8000);
        load_element(qgrad_pkg::ACT_LOAD_X, 4'd0, 4'd1, 16'sh7FFF);
        load_element(qgrad_pkg::ACT_LOAD_X, 4'd1, 4'd1, 16'sh7FFF);
        load_element(qgrad_pkg::ACT_LOAD_C, 4'd0, 4'd0, 16'sh0000);
        load_element(qgrad_pkg::ACT_LOAD_C, 4'd0, 4'd1, 16'sh7FFF);
        load_element(qgrad_pkg::ACT_LOAD_C, 4'd1, 4'd0, 16'sh8000);
        load_element(qgrad_pkg::ACT_LOAD_C, 4'd1, 4'd1, -16'sd1);
        // far corner of Q, and loads past the x and c column range that must be dropped
        load_element(qgrad_pkg::ACT_LOAD_Q, 4'd15, 4'd15, -16'sd1);
        load_element(qgrad_pkg::ACT_LOAD_X, 4'd15, 4'd15, 16'sh7FFF);
        load_element(qgrad_pkg::ACT_LOAD_C, 4'd15, 4'd4, 16'sh8000);
        run_compute();
        wait_idle();
        // single-element run, last set on the only element; unknown register left alone
        set_dims(5'd1, 5'd1, 5'd1);
        write_register(CFG_UNUSED_INDEX, 5'd31);
        run_compute();
        wait_idle();

        // random phases: register extremes first, then small random sizes; the idle
        // pattern cycles through none, sender, receiver, both
        phase = 0;
        while ((phase < 6 || stored_items < ITEM_TARGET) && phase < 40) begin
            wait_idle();
            idle_mode = t_idle_mode'(phase % 4);
            case (phase)
                0: set_dims(5'd31, 5'd2, 5'd31);   // 16 rows, 4 columns: most elements
                1: set_dims(5'd2, 5'd31, 5'd1);    // longest inner sum
                2: set_dims(5'd16, 5'd1, 5'd4);
                3: set_dims(5'd1, 5'd16, 5'd1);
                4: begin
                    // zero registers act as one; the receiver holds off so the
                    // output fills and the block stops taking items
                    set_dims(5'd0, 5'd0, 5'd0);
                    hold_off_asks++;
                end
                default: set_dims(5'($urandom_range(1, 5)), 5'($urandom_range(1, 5)),
                                  5'($urandom_range(1, 3) | ($urandom_range(0, 3) << 3)));
            endcase
            repeat ((phase < 4) ? 1 : 3)
                run_problem();
            phase++;
        end

        i_in_valid = 1'b0;
        idle_mode  = IDLE_NONE;
        wait_idle();
        repeat (20) @(negedge i_clk);
        if (grad_board.failures == 0 && grad_board.pending() == 0)
            $display("quadratic_gradient_qx_minus_c_unit verification clean");
        else
            $display("quadratic_gradient_qx_minus_c_unit verification failed");
        $finish;
    end

endmodule
